// File: rtl/core/pascal_subset_lexer_top_macros.svh
`ifndef PASCAL_SUBSET_LEXER_TOP_MACROS_SVH
`define PASCAL_SUBSET_LEXER_TOP_MACROS_SVH

// Same-cycle implication checked on every rising edge outside reset.
`define PSL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication checked on every rising edge outside reset.
`define PSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// File: rtl/core/psl_pkg.sv
package psl_pkg;

  localparam int KEYWORD_LEN_DEF = 9;

  localparam logic [4:0] TK_ASSIGN  = 5'd0;
  localparam logic [4:0] TK_COMMA   = 5'd1;
  localparam logic [4:0] TK_SEMI    = 5'd2;
  localparam logic [4:0] TK_EQUAL   = 5'd3;
  localparam logic [4:0] TK_PAREN   = 5'd4;
  localparam logic [4:0] TK_GREATER = 5'd5;
  localparam logic [4:0] TK_LESS    = 5'd6;
  localparam logic [4:0] TK_PLUS    = 5'd7;
  localparam logic [4:0] TK_MINUS   = 5'd8;
  localparam logic [4:0] TK_TIMES   = 5'd9;
  localparam logic [4:0] TK_POINT   = 5'd10;
  localparam logic [4:0] TK_COLON   = 5'd11;
  localparam logic [4:0] TK_KW_BASE = 5'd12;
  localparam logic [4:0] TK_ID      = 5'd27;
  localparam logic [4:0] TK_NUM     = 5'd28;
  localparam logic [4:0] TK_ERROR   = 5'd29;

  localparam int KW_COUNT = 15;
  localparam int KW_MAX   = 9;

  // Keyword text is right-justified: the first character sits in the highest used byte.
  localparam logic [KW_MAX*8-1:0] KW_TEXT [KW_COUNT] = '{
    "program", "var", "procedure", "function", "begin", "end", "if",
    "then", "else", "while", "do", "or", "and", "div", "not"
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd7, 4'd3, 4'd9, 4'd8, 4'd5, 4'd3, 4'd2,
    4'd4, 4'd4, 4'd5, 4'd2, 4'd2, 4'd3, 4'd3, 4'd3
  };

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef struct packed {
    logic [4:0] code;
    logic       last;
  } psl_tok_t;

  typedef struct packed {
    logic [1:0] cnt;
    psl_tok_t   t0;
    psl_tok_t   t1;
  } psl_push_t;

endpackage

// File: rtl/core/psl_scan.sv
module psl_scan
  import psl_pkg::*;
#(
  parameter int KEYWORD_LEN = KEYWORD_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic [7:0] char_byte,
  input  logic       end_flag,
  output psl_push_t  push
);

  localparam int IDX_W = $clog2(KEYWORD_LEN);

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COLON,
    MODE_WORD,
    MODE_NUM,
    MODE_HALT
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [3:0] len_r, len_nxt;
  logic [7:0] name_r [KEYWORD_LEN];

  logic       is_upper, alpha_hit, digit_hit, is_blank, is_alnum;
  logic [7:0] low_char;
  logic       sp_hit;
  logic [4:0] sp_code;
  logic [4:0] word_code;
  logic       st_emit, st_word;
  logic [4:0] st_code;
  mode_t      st_mode;
  logic       pre_emit, use_start, append, restart;
  logic [4:0] pre_code;
  logic [1:0] tok_cnt;
  logic [3:0] wr_idx;

  assign is_upper  = (char_byte >= 8'd65) && (char_byte <= 8'd90);
  assign alpha_hit = is_upper || ((char_byte >= 8'd97) && (char_byte <= 8'd122));
  assign digit_hit = (char_byte >= 8'd48) && (char_byte <= 8'd57);
  assign is_blank  = (char_byte <= CH_SPACE) || char_byte[7];
  assign is_alnum  = alpha_hit || digit_hit;
  assign low_char  = is_upper ? (char_byte + 8'd32) : char_byte;

  always_comb begin
    sp_hit  = 1'b1;
    sp_code = TK_ERROR;
    unique case (char_byte)
      CH_COMMA: sp_code = TK_COMMA;
      CH_SEMI:  sp_code = TK_SEMI;
      CH_EQUAL: sp_code = TK_EQUAL;
      CH_LPAR:  sp_code = TK_PAREN;
      CH_RPAR:  sp_code = TK_PAREN;
      CH_GT:    sp_code = TK_GREATER;
      CH_LT:    sp_code = TK_LESS;
      CH_PLUS:  sp_code = TK_PLUS;
      CH_MINUS: sp_code = TK_MINUS;
      CH_STAR:  sp_code = TK_TIMES;
      CH_POINT: sp_code = TK_POINT;
      CH_COLON: sp_code = TK_COLON;
      default:  sp_hit  = 1'b0;
    endcase
  end

  // The buffered word is compared against every keyword in parallel.
  always_comb begin
    logic m;
    word_code = TK_ID;
    for (int k = KW_COUNT - 1; k >= 0; k--) begin
      m = (len_r == KW_LEN[k]);
      for (int j = 0; j < KW_MAX; j++) begin
        if (4'(j) < KW_LEN[k]) begin
          if (name_r[j] != KW_TEXT[k][(32'(KW_LEN[k]) - 1 - j) * 8 +: 8]) begin
            m = 1'b0;
          end
        end
      end
      if (m) begin
        word_code = TK_KW_BASE + 5'(k);
      end
    end
  end

  always_comb begin
    st_emit = 1'b0;
    st_code = TK_ERROR;
    st_mode = MODE_IDLE;
    st_word = 1'b0;
    priority if (is_blank) begin
      st_mode = MODE_IDLE;
    end else if (sp_hit && (sp_code == TK_COLON)) begin
      st_mode = MODE_COLON;
    end else if (sp_hit) begin
      st_emit = 1'b1;
      st_code = sp_code;
    end else if (alpha_hit) begin
      st_mode = MODE_WORD;
      st_word = 1'b1;
    end else if (digit_hit) begin
      st_mode = MODE_NUM;
    end else begin
      st_emit = 1'b1;
      st_code = TK_ERROR;
      st_mode = MODE_HALT;
    end
  end

  always_comb begin
    pre_emit  = 1'b0;
    pre_code  = TK_ERROR;
    use_start = 1'b0;
    append    = 1'b0;
    mode_nxt  = mode_r;
    priority if (mode_r == MODE_HALT) begin
      mode_nxt = MODE_HALT;
    end else if (end_flag) begin
      mode_nxt = MODE_IDLE;
      unique case (mode_r)
        MODE_WORD: begin
          pre_emit = 1'b1;
          pre_code = word_code;
        end
        MODE_NUM: begin
          pre_emit = 1'b1;
          pre_code = TK_NUM;
        end
        MODE_COLON: begin
          pre_emit = 1'b1;
          pre_code = TK_COLON;
        end
        default: pre_emit = 1'b0;
      endcase
    end else begin
      unique case (mode_r)
        MODE_COLON: begin
          pre_emit = 1'b1;
          if (char_byte == CH_EQUAL) begin
            pre_code = TK_ASSIGN;
            mode_nxt = MODE_IDLE;
          end else begin
            pre_code  = TK_COLON;
            use_start = 1'b1;
            mode_nxt  = st_mode;
          end
        end
        MODE_WORD: begin
          if (is_alnum) begin
            append = 1'b1;
          end else begin
            pre_emit  = 1'b1;
            pre_code  = word_code;
            use_start = 1'b1;
            mode_nxt  = st_mode;
          end
        end
        MODE_NUM: begin
          priority if (digit_hit) begin
            mode_nxt = MODE_NUM;
          end else if (alpha_hit) begin
            pre_emit = 1'b1;
            pre_code = TK_ERROR;
            mode_nxt = MODE_HALT;
          end else begin
            pre_emit  = 1'b1;
            pre_code  = TK_NUM;
            use_start = 1'b1;
            mode_nxt  = st_mode;
          end
        end
        default: begin
          use_start = 1'b1;
          mode_nxt  = st_mode;
        end
      endcase
    end
  end

  assign restart = use_start && st_word;
  assign wr_idx  = restart ? 4'd0 : len_r;

  always_comb begin
    len_nxt = len_r;
    if (restart) begin
      len_nxt = 4'd1;
    end else if (append && (len_r != 4'd15)) begin
      len_nxt = len_r + 4'd1;
    end
  end

  assign tok_cnt = {1'b0, pre_emit} + {1'b0, use_start && st_emit};

  always_comb begin
    push.cnt     = go ? tok_cnt : 2'd0;
    push.t0.code = pre_emit ? pre_code : st_code;
    push.t0.last = (tok_cnt == 2'd1);
    push.t1.code = st_code;
    push.t1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      len_r  <= 4'd0;
    end else if (go) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && (append || restart) && (32'(wr_idx) < KEYWORD_LEN)) begin
      name_r[wr_idx[IDX_W-1:0]] <= low_char;
    end
  end

endmodule

// File: rtl/core/psl_outq.sv
module psl_outq
  import psl_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  psl_push_t  push,
  input  logic       out_ready,
  output logic       out_valid,
  output logic [4:0] out_token_code,
  output logic       out_last_token,
  output logic [2:0] count
);

  psl_tok_t         q_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_r, rd_r;
  logic [2:0]       cnt_r;
  logic             pop;

  assign out_valid      = (cnt_r != 3'd0);
  assign pop            = out_valid && out_ready;
  assign out_token_code = q_r[rd_r].code;
  assign out_last_token = q_r[rd_r].last;
  assign count          = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= 3'd0;
    end else begin
      wr_r  <= wr_r + push.cnt;
      rd_r  <= rd_r + Q_AW'(pop);
      cnt_r <= cnt_r + 3'(push.cnt) - 3'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      q_r[wr_r] <= push.t0;
    end
    if (push.cnt == 2'd2) begin
      q_r[wr_r + Q_AW'(1)] <= push.t1;
    end
  end

endmodule

// File: rtl/core/pascal_subset_lexer_top.sv
// Tokenizer for a small Pascal-like language. It takes one source byte per
// transaction and returns zero, one or two token codes, the last one of each
// byte flagged by out_last_token. An accepted byte is held in an input register
// and scanned from there against the lexer state and the keyword table, and its
// tokens enter a four-entry output queue, so a new byte can be taken every cycle
// unless the scan stage waits; a token is first visible once its byte has passed
// the input register and been written into the queue. The scan stage waits only
// while the queue holds over two tokens; a two-token byte takes two entries.
// After an error token the block yields nothing more until reset.

`include "pascal_subset_lexer_top_macros.svh"

module pascal_subset_lexer_top
  import psl_pkg::*;
#(
  parameter int KEYWORD_LEN = KEYWORD_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_byte,
  input  logic       in_end_flag,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] out_token_code,
  output logic       out_last_token
);

  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_end_r;
  logic       s1_go;
  logic [2:0] q_count;
  psl_push_t  push;

  assign s1_go    = s1_valid_r && (q_count <= 3'd2);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_char_r <= in_char_byte;
      s1_end_r  <= in_end_flag;
    end
  end

  psl_scan #(
    .KEYWORD_LEN (KEYWORD_LEN)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (s1_go),
    .char_byte (s1_char_r),
    .end_flag  (s1_end_r),
    .push      (push)
  );

  psl_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_token_code (out_token_code),
    .out_last_token (out_last_token),
    .count          (q_count)
  );

  `PSL_ASSERT_IMPL(a_q_bound, 1'b1, q_count <= 3'd4)
  `PSL_ASSERT_IMPL(a_two_last, push.cnt == 2'd2, push.t1.last && !push.t0.last)
  `PSL_ASSERT_IMPL(a_one_last, push.cnt == 2'd1, push.t0.last)
  `PSL_ASSERT_NEXT(a_q_drain, (push.cnt == 2'd0) && out_valid && out_ready,
                   q_count == ($past(q_count) - 3'd1))

endmodule
